[hw/rtl/rtpfua_pkg.sv]
// ----------------------------------------------------------------------------
// rtpfua_pkg
// Shared constants for the H.264 RTP packetizer: header layout, byte
// positions within a packet burst and configuration register indexes.
// ----------------------------------------------------------------------------
package rtpfua_pkg;

  localparam int unsigned MAX_PACKET_PAYLOAD = 1400;

  localparam logic [15:0] MAX_PAYLOAD_LEN = 16'(MAX_PACKET_PAYLOAD);
  localparam logic [10:0] MAX_PAYLOAD_PKT = 11'(MAX_PACKET_PAYLOAD);

  // fixed header bytes
  localparam logic [7:0]  RTP_VER_BYTE   = 8'h90;   // V=2, X=1, no CSRC
  localparam logic [15:0] EXT_PROFILE    = 16'hBEDE;
  localparam logic [15:0] EXT_WORDS      = 16'h0001;
  localparam logic [7:0]  ABS_SEND_IDLEN = 8'h32;   // id 3, three bytes follow
  localparam logic [23:0] SEND_TIME_MASK = 24'hFF_FFFF;

  // byte positions in a burst; 0..19 are the RTP header and extension
  localparam logic [4:0] POS_HDR_LAST  = 5'd19;
  localparam logic [4:0] POS_INDICATOR = 5'd20;
  localparam logic [4:0] POS_FU_HEADER = 5'd21;
  localparam logic [4:0] POS_DATA      = 5'd22;
  localparam logic [4:0] POS_FIRST     = 5'd0;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAYLOAD_TYPE = 2'd0,
    CFG_SSRC         = 2'd1,
    CFG_SINGLE_CODE  = 2'd2,
    CFG_FRAG_CODE    = 2'd3
  } cfg_reg_t;

  localparam logic OP_FRAME_START = 1'b0;
  localparam logic OP_DATA_BYTE   = 1'b1;

endpackage

[hw/rtl/rtp_h264_fua_packetizer.sv]
// ----------------------------------------------------------------------------
// rtp_h264_fua_packetizer
// Turns a frame-start transaction plus payload byte transactions into RTP
// packet bytes, single-NAL or FU-A fragmented.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries input transactions: s_tuser is the op (0 frame start,
//   1 payload byte), s_tdata the frame length, media time, send time and
//   payload byte. m_* carries one packet byte per transaction, m_tlast on
//   the final byte of each packet, m_tuser flags end of frame and the last
//   byte produced by one input transaction.
//   cfg_we/cfg_index/cfg_data write the payload type, SSRC and the two NAL
//   codes; write them only while the block is idle.
//   An accepted transaction is decoded into a burst register; a burst holds
//   0, 1, 21, 22 or 23 bytes, sent from position 0..22 one per cycle into
//   the output register, which drives m_*. Payload bytes inside a packet
//   sustain one per cycle while m_tready stays high; a packet start
//   occupies the burst register for its whole burst, and s_tready is
//   held low until its last byte moves to the output register.
//   A stalled m_tready holds the output register and, through it, the burst
//   and the input. Reset clears the sequence number, frame state, channel
//   valids and restores the register defaults.
// ----------------------------------------------------------------------------
module rtp_h264_fua_packetizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // frame_length[15:0], media_time[47:16], send_time[71:48], data_byte[79:72]
  input  logic [79:0]                       s_tdata,
  // op[0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_byte[7:0]
  output logic [7:0]                        m_tdata,
  output logic                              m_tlast,
  // frame_end[0], run_end[1]
  output logic [1:0]                        m_tuser,
  input  logic                              cfg_we,
  input  logic [rtpfua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpfua_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [6:0]  media_pt;
  logic [31:0] stream_source_id;
  logic [4:0]  single_nal_code;
  logic [4:0]  fragment_nal_code;

  // frame state
  logic [15:0] sequence_count;
  logic [31:0] latched_media_time;
  logic [15:0] bytes_left_in_frame;
  logic [10:0] bytes_left_in_packet;
  logic        fragmented_mode;
  logic        first_fragment_pending;

  // burst register
  logic        b_active;
  logic [4:0]  b_idx;
  logic        b_has_data;
  logic        b_frag;
  logic        b_marker;
  logic [15:0] b_seq;
  logic [31:0] b_ts;
  logic [23:0] b_send;
  logic [7:0]  b_data;
  logic        b_fu_s;
  logic        b_fu_e;
  logic        b_pkt_end;
  logic        b_frame_end;

  // input fields
  logic        in_op;
  logic [15:0] in_flen;
  logic [31:0] in_mtime;
  logic [23:0] in_send;
  logic [7:0]  in_data;

  assign in_op    = s_tuser;
  assign in_flen  = s_tdata[15:0];
  assign in_mtime = s_tdata[47:16];
  assign in_send  = s_tdata[71:48];
  assign in_data  = s_tdata[79:72];

  logic       accept;
  logic       advance;
  logic [4:0] last_pos;
  logic       burst_done;

  assign last_pos   = b_has_data ? rtpfua_pkg::POS_DATA : rtpfua_pkg::POS_INDICATOR;
  assign advance    = b_active && (!m_tvalid || m_tready);
  assign burst_done = advance && (b_idx == last_pos);
  assign s_tready   = !b_active || burst_done;
  assign accept     = s_tvalid && s_tready;

  // decode of one input transaction
  logic        d_emit;
  logic        d_header;
  logic        d_has_data;
  logic        d_frag;
  logic        d_marker;
  logic        d_fu_s;
  logic        d_fu_e;
  logic        d_pkt_end;
  logic        d_frame_end;
  logic        frame_last;
  logic        new_packet;
  logic [10:0] pkt_size;
  logic [10:0] pkt_left_dec;
  logic [15:0] frame_left_dec;

  logic [15:0] sequence_count_next;
  logic [31:0] latched_media_time_next;
  logic [15:0] bytes_left_in_frame_next;
  logic [10:0] bytes_left_in_packet_next;
  logic        fragmented_mode_next;
  logic        first_fragment_pending_next;

  always_comb begin
    frame_last     = bytes_left_in_frame <= rtpfua_pkg::MAX_PAYLOAD_LEN;
    new_packet     = bytes_left_in_packet == 11'd0;
    pkt_size       = frame_last ? bytes_left_in_frame[10:0] : rtpfua_pkg::MAX_PAYLOAD_PKT;
    pkt_left_dec   = (new_packet ? pkt_size : bytes_left_in_packet) - 11'd1;
    frame_left_dec = bytes_left_in_frame - 16'd1;

    d_emit      = 1'b0;
    d_header    = 1'b0;
    d_has_data  = 1'b0;
    d_frag      = 1'b0;
    d_marker    = 1'b1;
    d_fu_s      = 1'b0;
    d_fu_e      = 1'b0;
    d_pkt_end   = 1'b0;
    d_frame_end = 1'b0;

    sequence_count_next         = sequence_count;
    latched_media_time_next     = latched_media_time;
    bytes_left_in_frame_next    = bytes_left_in_frame;
    bytes_left_in_packet_next   = bytes_left_in_packet;
    fragmented_mode_next        = fragmented_mode;
    first_fragment_pending_next = first_fragment_pending;

    if (in_op == rtpfua_pkg::OP_FRAME_START) begin
      latched_media_time_next     = in_mtime;
      bytes_left_in_frame_next    = in_flen;
      bytes_left_in_packet_next   = 11'd0;
      fragmented_mode_next        = in_flen > rtpfua_pkg::MAX_PAYLOAD_LEN;
      first_fragment_pending_next = in_flen > rtpfua_pkg::MAX_PAYLOAD_LEN;
      if (in_flen == 16'd0) begin
        // empty frame: header and indicator only, closes at once
        d_emit              = 1'b1;
        d_header            = 1'b1;
        d_pkt_end           = 1'b1;
        d_frame_end         = 1'b1;
        sequence_count_next = sequence_count + 16'd1;
      end
    end else if (bytes_left_in_frame != 16'd0) begin
      d_emit     = 1'b1;
      d_has_data = 1'b1;
      d_header   = new_packet;
      d_frag     = fragmented_mode;
      d_marker   = fragmented_mode ? frame_last : 1'b1;
      d_fu_s     = first_fragment_pending;
      d_fu_e     = frame_last;
      if (new_packet) begin
        sequence_count_next = sequence_count + 16'd1;
        if (fragmented_mode) begin
          first_fragment_pending_next = 1'b0;
        end
      end
      bytes_left_in_packet_next = pkt_left_dec;
      bytes_left_in_frame_next  = frame_left_dec;
      d_pkt_end                 = pkt_left_dec == 11'd0;
      d_frame_end               = frame_left_dec == 16'd0;
    end
  end

  // byte at the current burst position
  logic [7:0] burst_byte;

  always_comb begin
    burst_byte = b_data;
    if (b_idx <= rtpfua_pkg::POS_HDR_LAST) begin
      case (b_idx)
        5'd0:    burst_byte = rtpfua_pkg::RTP_VER_BYTE;
        5'd1:    burst_byte = {b_marker, media_pt};
        5'd2:    burst_byte = b_seq[15:8];
        5'd3:    burst_byte = b_seq[7:0];
        5'd4:    burst_byte = b_ts[31:24];
        5'd5:    burst_byte = b_ts[23:16];
        5'd6:    burst_byte = b_ts[15:8];
        5'd7:    burst_byte = b_ts[7:0];
        5'd8:    burst_byte = stream_source_id[31:24];
        5'd9:    burst_byte = stream_source_id[23:16];
        5'd10:   burst_byte = stream_source_id[15:8];
        5'd11:   burst_byte = stream_source_id[7:0];
        5'd12:   burst_byte = rtpfua_pkg::EXT_PROFILE[15:8];
        5'd13:   burst_byte = rtpfua_pkg::EXT_PROFILE[7:0];
        5'd14:   burst_byte = rtpfua_pkg::EXT_WORDS[15:8];
        5'd15:   burst_byte = rtpfua_pkg::EXT_WORDS[7:0];
        5'd16:   burst_byte = rtpfua_pkg::ABS_SEND_IDLEN;
        5'd17:   burst_byte = b_send[23:16];
        5'd18:   burst_byte = b_send[15:8];
        default: burst_byte = b_send[7:0];
      endcase
    end else if (b_idx == rtpfua_pkg::POS_INDICATOR) begin
      burst_byte = b_frag ? {3'b000, fragment_nal_code} : {3'b001, single_nal_code};
    end else if (b_idx == rtpfua_pkg::POS_FU_HEADER) begin
      burst_byte = {b_fu_s, b_fu_e, 1'b0, fragment_nal_code};
    end
  end

  logic       at_last;
  logic [4:0] b_idx_next;

  assign at_last    = b_idx == last_pos;
  assign b_idx_next = (b_idx == rtpfua_pkg::POS_INDICATOR && !b_frag) ?
                      rtpfua_pkg::POS_DATA : b_idx + 5'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      media_pt          <= 7'd96;
      stream_source_id  <= '0;
      single_nal_code   <= 5'd1;
      fragment_nal_code <= 5'd28;
    end else if (cfg_we) begin
      unique case (rtpfua_pkg::cfg_reg_t'(cfg_index))
        rtpfua_pkg::CFG_PAYLOAD_TYPE: media_pt          <= cfg_data[6:0];
        rtpfua_pkg::CFG_SSRC:         stream_source_id  <= cfg_data[31:0];
        rtpfua_pkg::CFG_SINGLE_CODE:  single_nal_code   <= cfg_data[4:0];
        rtpfua_pkg::CFG_FRAG_CODE:    fragment_nal_code <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_count         <= '0;
      latched_media_time     <= '0;
      bytes_left_in_frame    <= '0;
      bytes_left_in_packet   <= '0;
      fragmented_mode        <= 1'b0;
      first_fragment_pending <= 1'b0;
    end else if (accept) begin
      sequence_count         <= sequence_count_next;
      latched_media_time     <= latched_media_time_next;
      bytes_left_in_frame    <= bytes_left_in_frame_next;
      bytes_left_in_packet   <= bytes_left_in_packet_next;
      fragmented_mode        <= fragmented_mode_next;
      first_fragment_pending <= first_fragment_pending_next;
    end
  end

  // burst register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_active <= 1'b0;
      b_idx    <= rtpfua_pkg::POS_FIRST;
    end else if (accept && d_emit) begin
      b_active <= 1'b1;
      b_idx    <= d_header ? rtpfua_pkg::POS_FIRST : rtpfua_pkg::POS_DATA;
    end else if (burst_done) begin
      b_active <= 1'b0;
    end else if (advance) begin
      b_idx <= b_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && d_emit) begin
      b_has_data  <= d_has_data;
      b_frag      <= d_frag;
      b_marker    <= d_marker;
      b_seq       <= sequence_count_next;
      b_ts        <= latched_media_time_next;
      b_send      <= in_send & rtpfua_pkg::SEND_TIME_MASK;
      b_data      <= in_data;
      b_fu_s      <= d_fu_s;
      b_fu_e      <= d_fu_e;
      b_pkt_end   <= d_pkt_end;
      b_frame_end <= d_frame_end;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= burst_byte;
      m_tlast <= at_last && b_pkt_end;
      m_tuser <= {at_last, at_last && b_frame_end};
    end
  end

endmodule

[hw/rtl/rtpfua_checker.sv]
// ----------------------------------------------------------------------------
// rtpfua_checker
// Port-level checks on the packetizer output channel, bound to the top level.
// ----------------------------------------------------------------------------
module rtpfua_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output changed while stalled");

  // end of frame only ever closes a packet
  a_frame_closes_packet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("frame end without packet end");

  // a packet end is always the last byte of its input transaction
  a_packet_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("packet end not on run end");

  // nothing is offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind rtp_h264_fua_packetizer rtpfua_checker u_rtpfua_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the H.264 RTP packetizer. Frame starts and payload
// bytes go in as stream transactions in random bursts while the output side
// stalls on a rolling pattern. A scoreboard predicts every packet byte and
// its end flags and compares them in order with the output stream.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MISMATCH_REPORTS = 10;
  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES     = 50;

  localparam logic [7:0] MARKER_BIT = 8'h80;
  localparam logic [7:0] NRI_ONE    = 8'h20;
  localparam logic [7:0] FU_START   = 8'h80;
  localparam logic [7:0] FU_END     = 8'h40;

  typedef struct packed {
    logic [7:0] value;
    logic       pkt_end;
    logic       frm_end;
    logic       run_end;
  } pkt_byte_t;

  class rtp_byte_scoreboard;
    // register copies
    logic [6:0]  media_pt     = 7'd96;
    logic [31:0] ssrc         = 32'd0;
    logic [4:0]  single_code  = 5'd1;
    logic [4:0]  frag_code    = 5'd28;
    // packetizer state
    logic [15:0] seq_num      = 16'd0;
    logic [31:0] frame_ts     = 32'd0;
    logic [15:0] frame_left   = 16'd0;
    logic [10:0] pkt_left     = 11'd0;
    bit          fragmented   = 1'b0;
    bit          first_frag   = 1'b0;

    pkt_byte_t   expected_bytes[$];

    int unsigned inputs_seen   = 0;
    int unsigned strays        = 0;
    int unsigned restarts      = 0;
    int unsigned frag_frames   = 0;
    int unsigned bytes_checked = 0;
    int unsigned packets_seen  = 0;
    int unsigned frames_seen   = 0;
    int unsigned mismatches    = 0;
    int unsigned unexpected    = 0;

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void set_reg(rtpfua_pkg::cfg_reg_t idx, logic [31:0] val);
      case (idx)
        rtpfua_pkg::CFG_PAYLOAD_TYPE: media_pt     = val[6:0];
        rtpfua_pkg::CFG_SSRC:         ssrc         = val;
        rtpfua_pkg::CFG_SINGLE_CODE:  single_code  = val[4:0];
        rtpfua_pkg::CFG_FRAG_CODE:    frag_code    = val[4:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] value, logic pe, logic fe, logic re);
      pkt_byte_t b;
      b.value   = value;
      b.pkt_end = pe;
      b.frm_end = fe;
      b.run_end = re;
      expected_bytes.insert(expected_bytes.size(), b);
    endfunction

    // rtp header plus the abs-send-time extension, 20 bytes, msb first
    function void push_header(logic marker, logic [23:0] stime);
      logic [159:0] hdr;
      seq_num = seq_num + 16'd1;
      hdr = {rtpfua_pkg::RTP_VER_BYTE, marker, media_pt, seq_num, frame_ts, ssrc,
             rtpfua_pkg::EXT_PROFILE, rtpfua_pkg::EXT_WORDS,
             rtpfua_pkg::ABS_SEND_IDLEN, stime};
      for (int i = 19; i >= 0; i--) push_byte(hdr[i*8 +: 8], 1'b0, 1'b0, 1'b0);
    endfunction

    function void note_input(logic op, logic [15:0] flen, logic [31:0] mtime,
                             logic [23:0] stime, logic [7:0] data);
      logic last_pkt;
      inputs_seen++;
      if (op == rtpfua_pkg::OP_FRAME_START) begin
        if (frame_left != 16'd0) restarts++;
        frame_ts   = mtime;
        frame_left = flen;
        pkt_left   = 11'd0;
        fragmented = flen > rtpfua_pkg::MAX_PAYLOAD_LEN;
        first_frag = fragmented;
        if (fragmented) frag_frames++;
        // an empty frame is a whole packet on its own
        if (flen == 16'd0) begin
          push_header(1'b1, stime);
          push_byte(NRI_ONE | {3'b000, single_code}, 1'b1, 1'b1, 1'b1);
        end
        return;
      end
      if (frame_left == 16'd0) begin
        strays++;
        return;
      end
      if (pkt_left == 11'd0) begin
        last_pkt = frame_left <= rtpfua_pkg::MAX_PAYLOAD_LEN;
        push_header(fragmented ? last_pkt : 1'b1, stime);
        if (fragmented) begin
          push_byte({3'b000, frag_code}, 1'b0, 1'b0, 1'b0);
          push_byte((first_frag ? FU_START : 8'h00) | (last_pkt ? FU_END : 8'h00) |
                    {3'b000, frag_code}, 1'b0, 1'b0, 1'b0);
          first_frag = 1'b0;
        end else begin
          push_byte(NRI_ONE | {3'b000, single_code}, 1'b0, 1'b0, 1'b0);
        end
        pkt_left = last_pkt ? frame_left[10:0] : rtpfua_pkg::MAX_PAYLOAD_PKT;
      end
      pkt_left   = pkt_left - 11'd1;
      frame_left = frame_left - 16'd1;
      push_byte(data, pkt_left == 11'd0, frame_left == 16'd0, 1'b1);
    endfunction

    function void check_byte(logic [7:0] value, logic pe, logic fe, logic re);
      pkt_byte_t want;
      bytes_checked++;
      if (pe === 1'b1) packets_seen++;
      if (fe === 1'b1) frames_seen++;
      if (expected_bytes.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MISMATCH_REPORTS)
          $display("unexpected output byte %0d: %02h last %0b frame_end %0b run_end %0b",
                   bytes_checked, value, pe, fe, re);
        return;
      end
      want = expected_bytes.pop_front();
      if (want.value !== value || want.pkt_end !== pe || want.frm_end !== fe ||
          want.run_end !== re) begin
        mismatches++;
        if (mismatches + unexpected <= MISMATCH_REPORTS)
          $display("byte %0d: expected %02h last %0b frame_end %0b run_end %0b, got %02h last %0b frame_end %0b run_end %0b",
                   bytes_checked, want.value, want.pkt_end, want.frm_end, want.run_end,
                   value, pe, fe, re);
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [79:0]                       s_tdata;
  logic                              s_tuser;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [7:0]                        m_tdata;
  logic                              m_tlast;
  logic [1:0]                        m_tuser;
  logic                              cfg_we;
  logic [rtpfua_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rtpfua_pkg::CFG_DATA_W-1:0] cfg_data;

  rtp_byte_scoreboard board;
  int unsigned        burst_left   = 0;
  int unsigned        quiet_cycles = 0;
  logic [15:0]        rx_cycle     = 16'd0;

  rtp_h264_fua_packetizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: check each transaction; the stall pattern steps through four modes by rx_cycle[8:7]
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      board.check_byte(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
    end
    rx_cycle <= rx_cycle + 16'd1;
    case (rx_cycle[8:7])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_tready <= (rx_cycle[1:0] != 2'd3);
      default: m_tready <= (rx_cycle[4:0] < 5'd18);
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d bytes still expected",
               STALL_LIMIT, board.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [15:0] flen, logic [31:0] mtime,
                           logic [23:0] stime, logic [7:0] data);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 240)
                                               : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {data, stime, mtime, flen};
    do @(posedge clk); while (s_tready !== 1'b1);
    board.note_input(op, flen, mtime, stime, data);
    burst_left--;
  endtask

  task automatic start_frame(logic [15:0] flen);
    send_item(rtpfua_pkg::OP_FRAME_START, flen, 32'($urandom), 24'($urandom),
              8'($urandom));
  endtask

  task automatic send_payload(int unsigned count);
    repeat (count)
      send_item(rtpfua_pkg::OP_DATA_BYTE, 16'($urandom), 32'($urandom), 24'($urandom),
                8'($urandom));
  endtask

  // wait for the output to drain, then wait on to catch any output from ignored bytes
  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(rtpfua_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic write_regs(logic [6:0] pt, logic [31:0] ssrc, logic [4:0] sc,
                            logic [4:0] fc);
    write_reg(rtpfua_pkg::CFG_PAYLOAD_TYPE, 32'(pt));
    write_reg(rtpfua_pkg::CFG_SSRC, ssrc);
    write_reg(rtpfua_pkg::CFG_SINGLE_CODE, 32'(sc));
    write_reg(rtpfua_pkg::CFG_FRAG_CODE, 32'(fc));
    cfg_we <= 1'b0;
  endtask

  // mostly whole short frames; some longer ones, some cut short by a restart, some stray bytes
  task automatic random_traffic(int unsigned target);
    int unsigned done_items;
    int unsigned sel;
    int unsigned nbytes;
    logic [15:0] flen;
    done_items = 0;
    while (done_items < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) flen = 16'd0;
      else if (sel < 82) flen = 16'($urandom_range(1, 24));
      else if (sel < 90) flen = 16'($urandom_range(25, 80));
      else flen = 16'($urandom);
      nbytes = (sel < 90) ? 32'(flen) : $urandom_range(0, 12);
      if (nbytes > 32'(flen)) nbytes = 32'(flen);
      start_frame(flen);
      send_payload(nbytes);
      done_items += 1 + nbytes;
      if (nbytes == 32'(flen) && $urandom_range(0, 9) == 0)
        send_payload($urandom_range(1, 2));
    end
  endtask

  initial begin
    board = new();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // register defaults: field extremes and the corner cases
    send_item(rtpfua_pkg::OP_DATA_BYTE, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
    send_item(rtpfua_pkg::OP_FRAME_START, 16'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
    send_item(rtpfua_pkg::OP_FRAME_START, 16'd1, 32'h0000_0000, 24'h00_0000, 8'h00);
    send_item(rtpfua_pkg::OP_DATA_BYTE, 16'h0000, 32'h0000_0000, 24'hFF_FFFF, 8'hFF);
    send_item(rtpfua_pkg::OP_FRAME_START, 16'd3, 32'h8000_0001, 24'h80_0001, 8'h00);
    send_item(rtpfua_pkg::OP_DATA_BYTE, 16'h0000, 32'h0000_0000, 24'h00_0000, 8'h00);
    send_item(rtpfua_pkg::OP_DATA_BYTE, 16'hFFFF, 32'hFFFF_FFFF, 24'h00_0000, 8'hFF);
    send_item(rtpfua_pkg::OP_DATA_BYTE, 16'h0000, 32'h0000_0000, 24'h00_0000, 8'h5A);
    send_item(rtpfua_pkg::OP_DATA_BYTE, 16'h0000, 32'h0000_0000, 24'h00_0000, 8'hA5);
    // restarts while a frame is still open
    start_frame(16'hFFFF);
    send_payload(2);
    start_frame(16'd0);
    start_frame(16'h8000);
    send_payload(1);
    start_frame(16'd2);
    send_payload(2);

    settle();
    write_regs(7'd0, 32'h0000_0000, 5'd0, 5'd0);
    // largest single packet and smallest fragmented frame, both cut short
    start_frame(rtpfua_pkg::MAX_PAYLOAD_LEN);
    send_payload(3);
    start_frame(rtpfua_pkg::MAX_PAYLOAD_LEN + 16'd1);
    send_payload(3);
    random_traffic(90);

    settle();
    write_regs(7'd127, 32'hFFFF_FFFF, 5'd31, 5'd31);
    // first fragments of long frames, each dropped by a restart
    start_frame(16'(2 * rtpfua_pkg::MAX_PACKET_PAYLOAD + 1));
    send_payload(3);
    start_frame(16'(rtpfua_pkg::MAX_PACKET_PAYLOAD + 100));
    send_payload(2);
    random_traffic(90);

    settle();
    write_regs(7'($urandom), 32'($urandom), 5'($urandom), 5'($urandom));
    random_traffic(90);
    settle();

    $display("covered %0d input transactions: %0d fragmented frames, %0d restarts, %0d stray bytes",
             board.inputs_seen, board.frag_frames, board.restarts, board.strays);
    $display("checked %0d output bytes in %0d packets over %0d frames, %0d mismatches",
             board.bytes_checked, board.packets_seen, board.frames_seen,
             board.mismatches + board.unexpected);
    if (board.mismatches == 0 && board.unexpected == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rtpfua_pkg.sv
hw/rtl/rtp_h264_fua_packetizer.sv
hw/rtl/rtpfua_checker.sv
dv/testbench.sv
